// File: rtl/eea_pkg.sv
`timescale 1ns / 1ps
package eea_pkg;

    // field widths
    localparam int POS_W  = 37;
    localparam int DIFF_W = 38;
    localparam int TRIG_W = 32;
    localparam int T_W    = 41;
    localparam int OUT_W  = 38;
    localparam int ANG_W  = 16;
    localparam int IDX_W  = 3;

    // rotation arithmetic: operands split into an unsigned low part and a signed high part
    localparam int LO_W   = 19;
    localparam int SUM_W  = 76;
    localparam int FRAC_W = 30;
    localparam int SAT_W  = SUM_W - FRAC_W;

    // CORDIC datapath
    localparam int CORDIC_STAGES = 24;
    localparam int ATAN_ENTRIES  = 40;
    localparam int NUM_CELLS     = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES
                                                                  : ATAN_ENTRIES;
    localparam int SHIFT_W       = $clog2(ATAN_ENTRIES);
    localparam int CW            = 61;
    localparam int ZW            = 34;
    localparam int SCALE_SH      = 20;
    localparam int MAG_W         = CW - 1;
    localparam int GAIN_W        = 30;
    localparam int ANG_SH        = 16;

    localparam logic [GAIN_W-1:0] INV_GAIN = 30'd652032874;
    localparam logic signed [ZW-1:0] HALF_TURN = ZW'(64'sd2147483648);
    localparam logic signed [ZW-1:0] ANG_ROUND = ZW'(64'sd32768);
    localparam logic signed [ANG_W-1:0] EL_MAX = 16'sd16384;
    localparam logic signed [ANG_W-1:0] EL_MIN = -16'sd16384;

    localparam logic [29:0] ATAN_TAB [0:ATAN_ENTRIES-1] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
        30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
        30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722,
        30'd20861, 30'd10430, 30'd5215, 30'd2608, 30'd1304,
        30'd652, 30'd326, 30'd163, 30'd81, 30'd41, 30'd20,
        30'd10, 30'd5, 30'd3, 30'd1, 30'd1, 30'd0, 30'd0, 30'd0,
        30'd0, 30'd0, 30'd0, 30'd0, 30'd0, 30'd0
    };

    typedef enum logic [IDX_W-1:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_ORIGIN_Z = 3'd2,
        REG_SIN_LON  = 3'd3,
        REG_COS_LON  = 3'd4,
        REG_SIN_LAT  = 3'd5,
        REG_COS_LAT  = 3'd6
    } cfg_reg_t;

    // one CORDIC vector in flight
    typedef struct packed {
        logic                 skip;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } cordic_t;

    // results that ride along with the vector
    typedef struct packed {
        logic signed [OUT_W-1:0] east;
        logic signed [OUT_W-1:0] north;
        logic signed [OUT_W-1:0] up;
        logic signed [ANG_W-1:0] azimuth;
    } look_t;

endpackage

// File: rtl/eea_rot.sv
`timescale 1ns / 1ps
module eea_rot (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic signed [eea_pkg::POS_W-1:0]    target_x,
    input  logic signed [eea_pkg::POS_W-1:0]    target_y,
    input  logic signed [eea_pkg::POS_W-1:0]    target_z,
    input  logic signed [eea_pkg::POS_W-1:0]    origin_x,
    input  logic signed [eea_pkg::POS_W-1:0]    origin_y,
    input  logic signed [eea_pkg::POS_W-1:0]    origin_z,
    input  logic signed [eea_pkg::TRIG_W-1:0]   sin_lon,
    input  logic signed [eea_pkg::TRIG_W-1:0]   cos_lon,
    input  logic signed [eea_pkg::TRIG_W-1:0]   sin_lat,
    input  logic signed [eea_pkg::TRIG_W-1:0]   cos_lat,
    output logic                                out_valid,
    output logic signed [eea_pkg::OUT_W-1:0]    east,
    output logic signed [eea_pkg::OUT_W-1:0]    north,
    output logic signed [eea_pkg::OUT_W-1:0]    up
);

    localparam int DH_W = eea_pkg::DIFF_W - eea_pkg::LO_W;
    localparam int TH_W = eea_pkg::T_W - eea_pkg::LO_W;
    localparam int PH_W = TH_W + eea_pkg::TRIG_W;
    localparam int PL_W = eea_pkg::LO_W + 1 + eea_pkg::TRIG_W;
    localparam int DP_W = DH_W + eea_pkg::TRIG_W;
    localparam logic signed [eea_pkg::SUM_W-1:0] HALF_LSB =
        eea_pkg::SUM_W'(64'sd536870912);
    localparam logic signed [eea_pkg::SAT_W-1:0] SAT_HI = 46'sd137438953471;
    localparam logic signed [eea_pkg::SAT_W-1:0] SAT_LO = -46'sd137438953472;

    // recombine high and low partial products
    function automatic logic signed [eea_pkg::SUM_W-1:0] join_pp(
        input logic signed [PH_W-1:0] hi,
        input logic signed [PL_W-1:0] lo
    );
        join_pp = (eea_pkg::SUM_W'(hi) <<< eea_pkg::LO_W) + eea_pkg::SUM_W'(lo);
    endfunction

    function automatic logic signed [eea_pkg::OUT_W-1:0] sat_pos(
        input logic signed [eea_pkg::SAT_W-1:0] v
    );
        if (v > SAT_HI)
            sat_pos = SAT_HI[eea_pkg::OUT_W-1:0];
        else if (v < SAT_LO)
            sat_pos = SAT_LO[eea_pkg::OUT_W-1:0];
        else
            sat_pos = v[eea_pkg::OUT_W-1:0];
    endfunction

    logic [4:0] v_reg;

    logic signed [eea_pkg::DIFF_W-1:0] dx_reg, dy_reg, dz1_reg, dz2_reg, dz3_reg;
    logic signed [eea_pkg::DIFF_W-1:0] dx_next, dy_next, dz_next;

    logic signed [DP_W-1:0] xc_hi_reg, xs_hi_reg, yc_hi_reg, ys_hi_reg;
    logic signed [PL_W-1:0] xc_lo_reg, xs_lo_reg, yc_lo_reg, ys_lo_reg;

    logic signed [eea_pkg::SUM_W-1:0] t_sum, e_sum, n_sum, u_sum;
    logic signed [eea_pkg::T_W-1:0]   t_reg, t_next;
    logic signed [eea_pkg::OUT_W-1:0] e3_reg, e4_reg, e5_reg, e_next;

    logic signed [DP_W-1:0] zc_hi_reg, zs_hi_reg;
    logic signed [PL_W-1:0] zc_lo_reg, zs_lo_reg;
    logic signed [PH_W-1:0] tc_hi_reg, ts_hi_reg;
    logic signed [PL_W-1:0] tc_lo_reg, ts_lo_reg;

    logic signed [eea_pkg::OUT_W-1:0] n_reg, u_reg, n_next, u_next;

    // form the differences, then the rounded sums of products
    always_comb
    begin
        dx_next = eea_pkg::DIFF_W'(target_x) - eea_pkg::DIFF_W'(origin_x);
        dy_next = eea_pkg::DIFF_W'(target_y) - eea_pkg::DIFF_W'(origin_y);
        dz_next = eea_pkg::DIFF_W'(target_z) - eea_pkg::DIFF_W'(origin_z);

        t_sum = join_pp(PH_W'(xc_hi_reg), xc_lo_reg)
              + join_pp(PH_W'(ys_hi_reg), ys_lo_reg) + HALF_LSB;
        e_sum = join_pp(PH_W'(yc_hi_reg), yc_lo_reg)
              - join_pp(PH_W'(xs_hi_reg), xs_lo_reg) + HALF_LSB;
        t_next = t_sum[eea_pkg::FRAC_W +: eea_pkg::T_W];
        e_next = sat_pos(e_sum[eea_pkg::SUM_W-1:eea_pkg::FRAC_W]);

        n_sum = join_pp(PH_W'(zc_hi_reg), zc_lo_reg)
              - join_pp(ts_hi_reg, ts_lo_reg) + HALF_LSB;
        u_sum = join_pp(tc_hi_reg, tc_lo_reg)
              + join_pp(PH_W'(zs_hi_reg), zs_lo_reg) + HALF_LSB;
        n_next = sat_pos(n_sum[eea_pkg::SUM_W-1:eea_pkg::FRAC_W]);
        u_next = sat_pos(u_sum[eea_pkg::SUM_W-1:eea_pkg::FRAC_W]);
    end

    // advance valid bits with the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[3:0], in_valid};
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg  <= dx_next;
            dy_reg  <= dy_next;
            dz1_reg <= dz_next;

            xc_hi_reg <= $signed(dx_reg[eea_pkg::DIFF_W-1:eea_pkg::LO_W]) * cos_lon;
            xc_lo_reg <= $signed({1'b0, dx_reg[eea_pkg::LO_W-1:0]}) * cos_lon;
            xs_hi_reg <= $signed(dx_reg[eea_pkg::DIFF_W-1:eea_pkg::LO_W]) * sin_lon;
            xs_lo_reg <= $signed({1'b0, dx_reg[eea_pkg::LO_W-1:0]}) * sin_lon;
            yc_hi_reg <= $signed(dy_reg[eea_pkg::DIFF_W-1:eea_pkg::LO_W]) * cos_lon;
            yc_lo_reg <= $signed({1'b0, dy_reg[eea_pkg::LO_W-1:0]}) * cos_lon;
            ys_hi_reg <= $signed(dy_reg[eea_pkg::DIFF_W-1:eea_pkg::LO_W]) * sin_lon;
            ys_lo_reg <= $signed({1'b0, dy_reg[eea_pkg::LO_W-1:0]}) * sin_lon;
            dz2_reg   <= dz1_reg;

            t_reg   <= t_next;
            e3_reg  <= e_next;
            dz3_reg <= dz2_reg;

            zc_hi_reg <= $signed(dz3_reg[eea_pkg::DIFF_W-1:eea_pkg::LO_W]) * cos_lat;
            zc_lo_reg <= $signed({1'b0, dz3_reg[eea_pkg::LO_W-1:0]}) * cos_lat;
            zs_hi_reg <= $signed(dz3_reg[eea_pkg::DIFF_W-1:eea_pkg::LO_W]) * sin_lat;
            zs_lo_reg <= $signed({1'b0, dz3_reg[eea_pkg::LO_W-1:0]}) * sin_lat;
            tc_hi_reg <= $signed(t_reg[eea_pkg::T_W-1:eea_pkg::LO_W]) * cos_lat;
            tc_lo_reg <= $signed({1'b0, t_reg[eea_pkg::LO_W-1:0]}) * cos_lat;
            ts_hi_reg <= $signed(t_reg[eea_pkg::T_W-1:eea_pkg::LO_W]) * sin_lat;
            ts_lo_reg <= $signed({1'b0, t_reg[eea_pkg::LO_W-1:0]}) * sin_lat;
            e4_reg    <= e3_reg;

            n_reg  <= n_next;
            u_reg  <= u_next;
            e5_reg <= e4_reg;
        end
    end

    assign out_valid = v_reg[4];
    assign east      = e5_reg;
    assign north     = n_reg;
    assign up        = u_reg;

endmodule

// File: rtl/eea_cordic_cell.sv
`timescale 1ns / 1ps
module eea_cordic_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic [eea_pkg::SHIFT_W-1:0]    shift,
    input  logic                           in_valid,
    input  eea_pkg::cordic_t               din,
    input  eea_pkg::look_t                 lin,
    output logic                           out_valid,
    output eea_pkg::cordic_t               dout,
    output eea_pkg::look_t                 lout
);

    logic signed [eea_pkg::CW-1:0] xs, ys;
    logic signed [eea_pkg::ZW-1:0] at;
    eea_pkg::cordic_t              c_next, c_reg;
    eea_pkg::look_t                l_reg;
    logic                          valid_reg;

    // rotate toward the x axis by one micro-angle
    always_comb
    begin
        xs = din.x >>> shift;
        ys = din.y >>> shift;
        at = eea_pkg::ZW'(eea_pkg::ATAN_TAB[shift]);
        c_next = din;
        if (!din.y[eea_pkg::CW-1])
        begin
            c_next.x = din.x + ys;
            c_next.y = din.y - xs;
            c_next.z = din.z + at;
        end
        else
        begin
            c_next.x = din.x - ys;
            c_next.y = din.y + xs;
            c_next.z = din.z - at;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg <= c_next;
            l_reg <= lin;
        end
    end

    assign out_valid = valid_reg;
    assign dout      = c_reg;
    assign lout      = l_reg;

endmodule

// File: rtl/eea_gain.sv
`timescale 1ns / 1ps
module eea_gain (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  eea_pkg::cordic_t  din,
    input  eea_pkg::look_t    lin,
    output logic              out_valid,
    output eea_pkg::cordic_t  dout,
    output eea_pkg::look_t    lout
);

    localparam int HALF_W = eea_pkg::MAG_W / 2;
    localparam int PP_W   = HALF_W + eea_pkg::GAIN_W;

    logic [1:0]                     v_reg;
    logic [PP_W-1:0]                p_lo_reg, p_hi_reg;
    eea_pkg::look_t                 l1_reg, l1_next, l2_reg;
    eea_pkg::cordic_t               c_reg, c_next;
    logic signed [eea_pkg::ZW-1:0]  az_sum;
    logic [PP_W:0]                  lo_round;
    logic [PP_W-1:0]                horiz;
    logic signed [eea_pkg::CW-1:0]  us;

    // finish the azimuth, then scale the magnitude by the inverse gain
    always_comb
    begin
        az_sum  = din.z + eea_pkg::ANG_ROUND;
        l1_next = lin;
        l1_next.azimuth = din.skip ? '0
                        : az_sum[eea_pkg::ANG_SH +: eea_pkg::ANG_W];

        lo_round = {1'b0, p_lo_reg} + (PP_W + 1)'(64'd536870912);
        horiz    = p_hi_reg + PP_W'(lo_round[PP_W:eea_pkg::FRAC_W]);
        us       = eea_pkg::CW'(l1_reg.up) <<< eea_pkg::SCALE_SH;

        c_next.x    = eea_pkg::CW'({1'b0, horiz});
        c_next.y    = us;
        c_next.z    = '0;
        c_next.skip = (horiz == '0) && (l1_reg.up == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_lo_reg <= din.x[HALF_W-1:0] * eea_pkg::INV_GAIN;
            p_hi_reg <= din.x[eea_pkg::MAG_W-1:HALF_W] * eea_pkg::INV_GAIN;
            l1_reg   <= l1_next;
            c_reg    <= c_next;
            l2_reg   <= l1_reg;
        end
    end

    assign out_valid = v_reg[1];
    assign dout      = c_reg;
    assign lout      = l2_reg;

endmodule

// File: rtl/ecef_to_enu_look_angles.sv
`timescale 1ns / 1ps
// ECEF to local east/north/up with azimuth and elevation.
// Input channel: in_valid/in_ready carry one target position per beat
// (target_x/y/z, signed millimetres). Output channel: out_valid/out_ready
// carry east, north, up (saturated to 38 bits), azimuth (65536 per turn)
// and elevation (16384 = pi/2). Configuration: cfg_valid/cfg_ready with
// cfg_index/cfg_data write the origin and the Q2.30 sines and cosines;
// cfg_ready is always high and writes take effect at once.
// Throughput: one beat per cycle while out_ready does not stall the pipe.
// Stages: five rotation stages, one quadrant stage, the azimuth cell chain
// (24 CORDIC stages per chain), two inverse-gain stages, the elevation
// cell chain and the output register.
// Every stage advances together; when out_valid is high and out_ready low
// the whole pipe holds and in_ready drops in the same cycle.
// Reset clears all valid bits and loads the default origin (zero) and the
// identity rotation; no clearing pass is needed.
module ecef_to_enu_look_angles (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [eea_pkg::POS_W-1:0]    target_x,
    input  logic signed [eea_pkg::POS_W-1:0]    target_y,
    input  logic signed [eea_pkg::POS_W-1:0]    target_z,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [eea_pkg::OUT_W-1:0]    east,
    output logic signed [eea_pkg::OUT_W-1:0]    north,
    output logic signed [eea_pkg::OUT_W-1:0]    up,
    output logic signed [eea_pkg::ANG_W-1:0]    azimuth,
    output logic signed [eea_pkg::ANG_W-1:0]    elevation,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [eea_pkg::IDX_W-1:0]           cfg_index,
    input  logic [eea_pkg::POS_W-1:0]           cfg_data
);

    logic en;

    logic signed [eea_pkg::POS_W-1:0]  origin_x_reg, origin_y_reg, origin_z_reg;
    logic signed [eea_pkg::TRIG_W-1:0] sin_lon_reg, cos_lon_reg, sin_lat_reg, cos_lat_reg;

    logic                             rot_valid;
    logic signed [eea_pkg::OUT_W-1:0] rot_e, rot_n, rot_u;

    logic                          prep_valid_reg;
    eea_pkg::cordic_t              prep_reg, prep_next;
    eea_pkg::look_t                prep_l_reg, prep_l_next;
    logic signed [eea_pkg::CW-1:0] xs, ys;

    logic             az_v [0:eea_pkg::NUM_CELLS];
    eea_pkg::cordic_t az_c [0:eea_pkg::NUM_CELLS];
    eea_pkg::look_t   az_l [0:eea_pkg::NUM_CELLS];
    logic             el_v [0:eea_pkg::NUM_CELLS];
    eea_pkg::cordic_t el_c [0:eea_pkg::NUM_CELLS];
    eea_pkg::look_t   el_l [0:eea_pkg::NUM_CELLS];

    logic signed [eea_pkg::ZW-1:0]           el_sum;
    logic signed [eea_pkg::ZW-eea_pkg::ANG_SH-1:0] el_raw;
    logic signed [eea_pkg::ANG_W-1:0]        el_next;

    logic                             out_valid_reg;
    logic signed [eea_pkg::OUT_W-1:0] east_reg, north_reg, up_reg;
    logic signed [eea_pkg::ANG_W-1:0] azimuth_reg, elevation_reg;

    // the whole pipe moves unless a finished beat is stuck at the output
    assign en        = !out_valid_reg || out_ready;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            origin_z_reg <= '0;
            sin_lon_reg  <= '0;
            cos_lon_reg  <= 32'sd1073741824;
            sin_lat_reg  <= '0;
            cos_lat_reg  <= 32'sd1073741824;
        end
        else if (cfg_valid)
        begin
            unique case (eea_pkg::cfg_reg_t'(cfg_index))
                eea_pkg::REG_ORIGIN_X: origin_x_reg <= cfg_data;
                eea_pkg::REG_ORIGIN_Y: origin_y_reg <= cfg_data;
                eea_pkg::REG_ORIGIN_Z: origin_z_reg <= cfg_data;
                eea_pkg::REG_SIN_LON:  sin_lon_reg  <= cfg_data[eea_pkg::TRIG_W-1:0];
                eea_pkg::REG_COS_LON:  cos_lon_reg  <= cfg_data[eea_pkg::TRIG_W-1:0];
                eea_pkg::REG_SIN_LAT:  sin_lat_reg  <= cfg_data[eea_pkg::TRIG_W-1:0];
                eea_pkg::REG_COS_LAT:  cos_lat_reg  <= cfg_data[eea_pkg::TRIG_W-1:0];
                default: ;
            endcase
        end
    end

    eea_rot u_rot (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .target_x  (target_x),
        .target_y  (target_y),
        .target_z  (target_z),
        .origin_x  (origin_x_reg),
        .origin_y  (origin_y_reg),
        .origin_z  (origin_z_reg),
        .sin_lon   (sin_lon_reg),
        .cos_lon   (cos_lon_reg),
        .sin_lat   (sin_lat_reg),
        .cos_lat   (cos_lat_reg),
        .out_valid (rot_valid),
        .east      (rot_e),
        .north     (rot_n),
        .up        (rot_u)
    );

    // fold the left half plane onto the right and preload a half turn
    always_comb
    begin
        xs = eea_pkg::CW'(rot_n) <<< eea_pkg::SCALE_SH;
        ys = eea_pkg::CW'(rot_e) <<< eea_pkg::SCALE_SH;
        prep_next.skip = (rot_n == '0) && (rot_e == '0);
        if (rot_n[eea_pkg::OUT_W-1])
        begin
            prep_next.x = -xs;
            prep_next.y = -ys;
            prep_next.z = rot_e[eea_pkg::OUT_W-1] ? -eea_pkg::HALF_TURN
                                                  : eea_pkg::HALF_TURN;
        end
        else
        begin
            prep_next.x = xs;
            prep_next.y = ys;
            prep_next.z = '0;
        end
        prep_l_next.east    = rot_e;
        prep_l_next.north   = rot_n;
        prep_l_next.up      = rot_u;
        prep_l_next.azimuth = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prep_valid_reg <= 1'b0;
        else if (en)
            prep_valid_reg <= rot_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prep_reg   <= prep_next;
            prep_l_reg <= prep_l_next;
        end
    end

    assign az_v[0] = prep_valid_reg;
    assign az_c[0] = prep_reg;
    assign az_l[0] = prep_l_reg;

    // azimuth chain
    for (genvar i = 0; i < eea_pkg::NUM_CELLS; i++)
    begin : g_az
        eea_cordic_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .shift     (eea_pkg::SHIFT_W'(i)),
            .in_valid  (az_v[i]),
            .din       (az_c[i]),
            .lin       (az_l[i]),
            .out_valid (az_v[i+1]),
            .dout      (az_c[i+1]),
            .lout      (az_l[i+1])
        );
    end

    eea_gain u_gain (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (az_v[eea_pkg::NUM_CELLS]),
        .din       (az_c[eea_pkg::NUM_CELLS]),
        .lin       (az_l[eea_pkg::NUM_CELLS]),
        .out_valid (el_v[0]),
        .dout      (el_c[0]),
        .lout      (el_l[0])
    );

    // elevation chain
    for (genvar i = 0; i < eea_pkg::NUM_CELLS; i++)
    begin : g_el
        eea_cordic_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .shift     (eea_pkg::SHIFT_W'(i)),
            .in_valid  (el_v[i]),
            .din       (el_c[i]),
            .lin       (el_l[i]),
            .out_valid (el_v[i+1]),
            .dout      (el_c[i+1]),
            .lout      (el_l[i+1])
        );
    end

    // round and clamp the elevation
    always_comb
    begin
        el_sum = el_c[eea_pkg::NUM_CELLS].z + eea_pkg::ANG_ROUND;
        el_raw = el_sum[eea_pkg::ZW-1:eea_pkg::ANG_SH];
        if (el_c[eea_pkg::NUM_CELLS].skip)
            el_next = '0;
        else if (el_raw > (eea_pkg::ZW - eea_pkg::ANG_SH)'(eea_pkg::EL_MAX))
            el_next = eea_pkg::EL_MAX;
        else if (el_raw < (eea_pkg::ZW - eea_pkg::ANG_SH)'(eea_pkg::EL_MIN))
            el_next = eea_pkg::EL_MIN;
        else
            el_next = el_raw[eea_pkg::ANG_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= el_v[eea_pkg::NUM_CELLS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            east_reg      <= el_l[eea_pkg::NUM_CELLS].east;
            north_reg     <= el_l[eea_pkg::NUM_CELLS].north;
            up_reg        <= el_l[eea_pkg::NUM_CELLS].up;
            azimuth_reg   <= el_l[eea_pkg::NUM_CELLS].azimuth;
            elevation_reg <= el_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign east      = east_reg;
    assign north     = north_reg;
    assign up        = up_reg;
    assign azimuth   = azimuth_reg;
    assign elevation = elevation_reg;

    a_az_zero_vector: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && east == '0 && north == '0 |-> azimuth == '0)
        else $error("azimuth nonzero for zero horizontal vector");

    a_el_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (elevation <= eea_pkg::EL_MAX && elevation >= eea_pkg::EL_MIN))
        else $error("elevation out of range");

    a_el_zero_vector: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && east == '0 && north == '0 && up == '0 |-> elevation == '0)
        else $error("elevation nonzero for zero vector");

endmodule

// File: verif/look_angle_checker.sv
`timescale 1ns / 1ps
module look_angle_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic signed [eea_pkg::POS_W-1:0]    target_x,
    input  logic signed [eea_pkg::POS_W-1:0]    target_y,
    input  logic signed [eea_pkg::POS_W-1:0]    target_z,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic signed [eea_pkg::OUT_W-1:0]    east,
    input  logic signed [eea_pkg::OUT_W-1:0]    north,
    input  logic signed [eea_pkg::OUT_W-1:0]    up,
    input  logic signed [eea_pkg::ANG_W-1:0]    azimuth,
    input  logic signed [eea_pkg::ANG_W-1:0]    elevation,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [eea_pkg::IDX_W-1:0]           cfg_index,
    input  logic [eea_pkg::POS_W-1:0]           cfg_data,
    output int                                  fail_count,
    output int                                  pending,
    output int                                  seen
);

    typedef struct {
        longint e;
        longint n;
        longint u;
        longint az;
        longint el;
    } look_result_t;

    localparam longint POS_HI = 64'sd137438953471;
    localparam longint POS_LO = -64'sd137438953472;

    look_result_t expected_looks[$];
    longint org_x, org_y, org_z, s_lon, c_lon, s_lat, c_lat;

    function automatic longint floor_shift(longint v, int k);
        return v >>> k;
    endfunction

    // round half up of (a1*b1 + a2*b2) / 2^30, split to stay within 64 bits
    function automatic longint rot_q30(longint a1, longint b1, longint a2, longint b2);
        longint h1, h2, l1, l2, lo;
        h1 = a1 >>> eea_pkg::FRAC_W;
        h2 = a2 >>> eea_pkg::FRAC_W;
        l1 = a1 - (h1 <<< eea_pkg::FRAC_W);
        l2 = a2 - (h2 <<< eea_pkg::FRAC_W);
        lo = l1 * b1 + l2 * b2 + (64'sd1 <<< 29);
        return h1 * b1 + h2 * b2 + (lo >>> eea_pkg::FRAC_W);
    endfunction

    function automatic longint clamp_pos(longint v);
        if (v > POS_HI) return POS_HI;
        if (v < POS_LO) return POS_LO;
        return v;
    endfunction

    // vector toward the x axis, accumulating the angle
    function automatic longint rotate_to_axis(longint x, longint y, inout longint ang);
        longint xs, ys;
        for (int i = 0; i < eea_pkg::CORDIC_STAGES && i < eea_pkg::ATAN_ENTRIES; i++)
        begin
            ys = y >>> i;
            xs = x >>> i;
            if (y >= 0)
            begin
                x += ys; y -= xs; ang += longint'(eea_pkg::ATAN_TAB[i]);
            end
            else
            begin
                x -= ys; y += xs; ang -= longint'(eea_pkg::ATAN_TAB[i]);
            end
        end
        return x;
    endfunction

    function automatic look_result_t predict_look(longint tx, longint ty, longint tz);
        look_result_t r;
        longint dx, dy, dz, t, xs, ys, us, az_acc, el_acc, mag, horiz, el;
        dx = tx - org_x;
        dy = ty - org_y;
        dz = tz - org_z;
        t = rot_q30(dx, c_lon, dy, s_lon);
        r.e = clamp_pos(rot_q30(dy, c_lon, dx, -s_lon));
        r.n = clamp_pos(rot_q30(dz, c_lat, t, -s_lat));
        r.u = clamp_pos(rot_q30(t, c_lat, dz, s_lat));
        xs = r.n <<< eea_pkg::SCALE_SH;
        ys = r.e <<< eea_pkg::SCALE_SH;
        us = r.u <<< eea_pkg::SCALE_SH;
        az_acc = 0;
        el_acc = 0;
        mag = 0;
        if (xs != 0 || ys != 0)
        begin
            if (xs < 0)
            begin
                az_acc = (ys >= 0) ? (64'sd1 <<< 31) : -(64'sd1 <<< 31);
                xs = -xs;
                ys = -ys;
            end
            mag = rotate_to_axis(xs, ys, az_acc);
        end
        horiz = rot_q30(mag, longint'(eea_pkg::INV_GAIN), 0, 0);
        if (horiz != 0 || us != 0)
            void'(rotate_to_axis(horiz, us, el_acc));
        r.az = longint'(16'((az_acc + 32768) >>> eea_pkg::ANG_SH));
        el = (el_acc + 32768) >>> eea_pkg::ANG_SH;
        if (el > 16384) el = 16384;
        if (el < -16384) el = -16384;
        r.el = el;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        look_result_t w;
        if (!rst_n)
        begin
            org_x = 0; org_y = 0; org_z = 0;
            s_lon = 0; c_lon = 64'sd1 <<< 30;
            s_lat = 0; c_lat = 64'sd1 <<< 30;
            fail_count = 0;
            seen = 0;
            pending = expected_looks.size();
        end
        else
        begin
            // predict from the register values that held before this edge
            if (in_valid && in_ready)
                expected_looks.push_back(predict_look(target_x, target_y, target_z));
            if (out_valid && out_ready)
            begin
                seen++;
                if (expected_looks.size() == 0)
                begin
                    $display("unexpected result beat at %0t", $realtime);
                    fail_count++;
                end
                else
                begin
                    w = expected_looks.pop_front();
                    if (longint'(east) != w.e) report_mismatch("east", east, w.e);
                    if (longint'(north) != w.n) report_mismatch("north", north, w.n);
                    if (longint'(up) != w.u) report_mismatch("up", up, w.u);
                    if (longint'(azimuth) != w.az) report_mismatch("azimuth", azimuth, w.az);
                    if (longint'(elevation) != w.el)
                        report_mismatch("elevation", elevation, w.el);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    eea_pkg::REG_ORIGIN_X: org_x = longint'(signed'(cfg_data));
                    eea_pkg::REG_ORIGIN_Y: org_y = longint'(signed'(cfg_data));
                    eea_pkg::REG_ORIGIN_Z: org_z = longint'(signed'(cfg_data));
                    eea_pkg::REG_SIN_LON:
                        s_lon = longint'(signed'(cfg_data[eea_pkg::TRIG_W-1:0]));
                    eea_pkg::REG_COS_LON:
                        c_lon = longint'(signed'(cfg_data[eea_pkg::TRIG_W-1:0]));
                    eea_pkg::REG_SIN_LAT:
                        s_lat = longint'(signed'(cfg_data[eea_pkg::TRIG_W-1:0]));
                    eea_pkg::REG_COS_LAT:
                        c_lat = longint'(signed'(cfg_data[eea_pkg::TRIG_W-1:0]));
                    default: ;
                endcase
            end
            pending = expected_looks.size();
        end
    end

endmodule

// File: verif/tb_ecef_to_enu_look_angles.sv
`timescale 1ns / 1ps
module tb_ecef_to_enu_look_angles;

    localparam int LATENCY = 9 + 2 * eea_pkg::NUM_CELLS;
    localparam longint P_MAX = 64'sd68719476735;
    localparam longint P_MIN = -64'sd68719476736;
    localparam longint Q_ONE = 64'sd1073741824;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [eea_pkg::POS_W-1:0] target_x = '0, target_y = '0, target_z = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [eea_pkg::OUT_W-1:0] east, north, up;
    logic signed [eea_pkg::ANG_W-1:0] azimuth, elevation;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [eea_pkg::IDX_W-1:0] cfg_index = '0;
    logic [eea_pkg::POS_W-1:0] cfg_data = '0;
    int fail_count, pending, seen;
    int sent = 0;
    bit stim_done = 0;

    ecef_to_enu_look_angles dut (.*);
    look_angle_checker checker_i (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // stall the result side in alternating patterns
    initial
    begin
        int mode;
        mode = 0;
        forever
        begin
            repeat ($urandom_range(20, 200))
            begin
                @(posedge clk);
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(0, 3) != 0);
                    2: out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= $urandom_range(0, 1);
                endcase
            end
            if (stim_done) mode = 0;
            else mode = $urandom_range(0, 3);
        end
    end

    function automatic longint rand_pos(int kind);
        longint v;
        case (kind)
            0: v = P_MAX;
            1: v = P_MIN;
            2: v = longint'($urandom_range(0, 2000000)) - 1000000;
            3: v = 0;
            default:
            begin
                v = {$urandom, $urandom};
                v = longint'(37'(v)) <<< 27 >>> 27;
                v = longint'(signed'(37'(v)));
            end
        endcase
        return v;
    endfunction

    task automatic send_beat(longint x, longint y, longint z);
        in_valid <= 1'b1;
        target_x <= x[eea_pkg::POS_W-1:0];
        target_y <= y[eea_pkg::POS_W-1:0];
        target_z <= z[eea_pkg::POS_W-1:0];
        do @(posedge clk); while (!in_ready);
        sent++;
    endtask

    task automatic pause_beats();
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
    endtask

    // drain the pipe before touching registers
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_reg(eea_pkg::cfg_reg_t idx, longint val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[eea_pkg::POS_W-1:0];
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic set_frame(longint ox, longint oy, longint oz,
                             longint sl, longint cl, longint sp, longint cp);
        write_reg(eea_pkg::REG_ORIGIN_X, ox);
        write_reg(eea_pkg::REG_ORIGIN_Y, oy);
        write_reg(eea_pkg::REG_ORIGIN_Z, oz);
        write_reg(eea_pkg::REG_SIN_LON, sl);
        write_reg(eea_pkg::REG_COS_LON, cl);
        write_reg(eea_pkg::REG_SIN_LAT, sp);
        write_reg(eea_pkg::REG_COS_LAT, cp);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_burst(int count);
        int left;
        left = count;
        while (left > 0)
        begin
            repeat ($urandom_range(1, 40))
            begin
                if (left > 0)
                begin
                    send_beat(rand_pos($urandom_range(0, 6)), rand_pos($urandom_range(0, 6)),
                              rand_pos($urandom_range(0, 6)));
                    left--;
                end
            end
            if ($urandom_range(0, 2) == 0) pause_beats();
        end
    endtask

    initial
    begin
        longint sv, cv;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset frame, axes, zero vector, half-turn and field extremes
        send_beat(0, 0, 0);
        send_beat(0, 0, 1000);
        send_beat(0, 0, -1000);
        send_beat(0, 1000, 0);
        send_beat(0, -1000, 0);
        send_beat(1000, 0, 0);
        send_beat(-1000, 0, 0);
        send_beat(-1000, -1, 0);
        send_beat(0, -1000, 5);
        send_beat(P_MAX, P_MAX, P_MAX);
        send_beat(P_MIN, P_MIN, P_MIN);
        send_beat(P_MAX, P_MIN, 0);
        send_beat(3, 4, 5);
        drain();

        // extreme origin and trig, forcing saturation
        set_frame(P_MIN, P_MAX, P_MIN, -Q_ONE, -Q_ONE, Q_ONE, -Q_ONE);
        send_beat(P_MAX, P_MIN, P_MAX);
        send_beat(P_MIN, P_MAX, P_MIN);
        send_beat(0, 0, 0);
        pause_beats();
        send_beat(P_MIN, P_MAX, P_MIN);
        drain();

        // out-of-range trig words, all bits toggled
        set_frame(-1, -1, -1, 32'h7fffffff, -64'sd2147483648, 32'h7fffffff,
                  -64'sd2147483648);
        send_beat(P_MAX, 0, P_MIN);
        send_beat(1, 1, 1);
        drain();

        // random phases, one frame and a burst of targets each
        for (int ph = 0; ph < 8; ph++)
        begin
            sv = longint'($urandom_range(0, 2 * 1073741824)) - Q_ONE;
            cv = longint'($urandom_range(0, 2 * 1073741824)) - Q_ONE;
            set_frame(rand_pos($urandom_range(0, 6)), rand_pos($urandom_range(0, 6)),
                      rand_pos($urandom_range(0, 6)), sv, cv,
                      longint'($urandom_range(0, 2 * 1073741824)) - Q_ONE,
                      longint'($urandom_range(0, 2 * 1073741824)) - Q_ONE);
            random_burst(250);
            drain();
        end

        set_frame(0, 0, 0, 0, Q_ONE, 0, Q_ONE);
        send_beat(10, 20, 30);
        stim_done = 1;
        drain();

        $display("covered %0d targets and %0d results over 11 frame settings",
                 sent, seen);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("FAIL");
        $finish;
    end

endmodule
